[hdl/staircase_search_sorted_matrix_defines.svh]
// Assertion macros shared by the checker files of this block.
// Both sample on clk and are switched off while rst is high.
`ifndef STAIRCASE_SEARCH_SORTED_MATRIX_DEFINES_SVH
`define STAIRCASE_SEARCH_SORTED_MATRIX_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ssm_pkg.sv]
package ssm_pkg;

  // Default sizes for the top level parameters.
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the transaction payloads.
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 7;

  // Register port geometry.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Reset values of the size registers.
  localparam logic [SIZE_W-1:0] NUM_ROWS_RST = 7'd64;
  localparam logic [SIZE_W-1:0] NUM_COLS_RST = 7'd64;

  // Function codes of an input transaction.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] hit_row;
    logic [POS_W-1:0] hit_col;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_elem;
    logic start_walk;
    logic issue_read;
    logic compare_step;
    logic load_out;
  } ssm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_over;
    logic key_match;
  } ssm_status_t;

endpackage

[hdl/ssm_regs.sv]
module ssm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssm_pkg::PADDR_W-1:0] paddr,
  input  logic [ssm_pkg::PDATA_W-1:0] pwdata,
  output logic [ssm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [ssm_pkg::SIZE_W-1:0]  num_rows,
  output logic [ssm_pkg::SIZE_W-1:0]  num_cols
);

  logic [ssm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  // Registers sit at word addresses; the low address bits are ignored.
  assign reg_idx = paddr[ssm_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  // Size registers keep the low seven bits of the written data.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= ssm_pkg::NUM_ROWS_RST;
      num_cols <= ssm_pkg::NUM_COLS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ssm_pkg::REG_NUM_ROWS: num_rows <= pwdata[ssm_pkg::SIZE_W-1:0];
        ssm_pkg::REG_NUM_COLS: num_cols <= pwdata[ssm_pkg::SIZE_W-1:0];
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (reg_idx)
      ssm_pkg::REG_NUM_ROWS: prdata = ssm_pkg::PDATA_W'(num_rows);
      ssm_pkg::REG_NUM_COLS: prdata = ssm_pkg::PDATA_W'(num_cols);
    endcase
  end

endmodule

[hdl/ssm_datapath.sv]
module ssm_datapath #(
  parameter int MAX_ROWS   = ssm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = ssm_pkg::MAX_COLS_DEF,
  parameter int DATA_WIDTH = ssm_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  ssm_pkg::ssm_cmd_t          cmd,
  input  ssm_pkg::in_item_t          in_data,
  input  logic [ssm_pkg::SIZE_W-1:0] num_rows,
  input  logic [ssm_pkg::SIZE_W-1:0] num_cols,
  output ssm_pkg::ssm_status_t       status,
  output ssm_pkg::out_item_t         out_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int CC_W   = $clog2(MAX_COLS + 1);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic signed [DATA_WIDTH-1:0] key;

  logic [RC_W-1:0]   row_idx;
  logic [CC_W-1:0]   col_cnt;
  logic [RC_W-1:0]   eff_rows;
  logic [CC_W-1:0]   eff_cols;
  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic                      found;
  logic [ssm_pkg::POS_W-1:0] hit_row;
  logic [ssm_pkg::POS_W-1:0] hit_col;

  // The size register values are clamped to the built matrix size.
  assign eff_rows = (32'(num_rows) > MAX_ROWS) ? RC_W'(MAX_ROWS) : RC_W'(num_rows);
  assign eff_cols = (32'(num_cols) > MAX_COLS) ? CC_W'(MAX_COLS) : CC_W'(num_cols);

  // Element addressing, row major; writes outside the store are dropped.
  assign wr_ok   = (32'(in_data.row) < MAX_ROWS) && (32'(in_data.col) < MAX_COLS);
  assign wr_addr = ADDR_W'(32'(in_data.row) * MAX_COLS + 32'(in_data.col));
  assign rd_addr = ADDR_W'(32'(row_idx) * MAX_COLS + 32'(col_cnt) - 32'd1);

  // Matrix memory: one write port for loads, one registered read for the walk.
  always_ff @(posedge clk) begin
    if (cmd.write_elem && wr_ok) begin
      mem[wr_addr] <= DATA_WIDTH'(in_data.value);
    end
    if (cmd.issue_read) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Walk position and running result; col_cnt is one above the current column.
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      row_idx <= '0;
      col_cnt <= eff_cols;
      key     <= DATA_WIDTH'(in_data.value);
      found   <= 1'b0;
      hit_row <= '0;
      hit_col <= '0;
    end else if (cmd.compare_step) begin
      if (rd_data == key) begin
        found   <= 1'b1;
        hit_row <= ssm_pkg::POS_W'(row_idx);
        hit_col <= ssm_pkg::POS_W'(col_cnt - CC_W'(1));
      end else if (rd_data > key) begin
        col_cnt <= col_cnt - CC_W'(1);
      end else begin
        row_idx <= row_idx + RC_W'(1);
      end
    end
  end

  assign status.walk_over = (row_idx >= eff_rows) || (col_cnt == '0);
  assign status.key_match = (rd_data == key);

  // Output register for the finished search.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.found   <= found;
      out_data.hit_row <= hit_row;
      out_data.hit_col <= hit_col;
    end
  end

endmodule

[hdl/ssm_ctrl.sv]
module ssm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_func,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  ssm_pkg::ssm_status_t status,
  output ssm_pkg::ssm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Commands decoded from the current state.
  always_comb begin
    cmd.write_elem   = (state == ST_IDLE) && in_valid && (in_func == ssm_pkg::FUNC_LOAD);
    cmd.start_walk   = (state == ST_IDLE) && in_valid && (in_func == ssm_pkg::FUNC_SEARCH);
    cmd.issue_read   = (state == ST_READ) && !status.walk_over;
    cmd.compare_step = (state == ST_CMP);
    cmd.load_out     = (state == ST_DONE) && out_free;
  end

  // Walk sequencing: each step is a memory read followed by a compare.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.start_walk) state_next = ST_READ;
      ST_READ: state_next = status.walk_over ? ST_DONE : ST_CMP;
      ST_CMP:  state_next = status.key_match ? ST_DONE : ST_READ;
      ST_DONE: if (out_free) state_next = ST_IDLE;
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/staircase_search_sorted_matrix.sv]
// Staircase search over a matrix whose rows and columns ascend. A load transaction writes
// one element into the on-chip store and leaves the block ready, so loads stream back
// to back. A search transaction walks from the top-right corner of the configured area,
// one element per step, and returns one result transaction. Every step is a registered
// read of the matrix memory followed by a compare. The read state detects that the walk
// has left the area, and the done state loads the result register. A search holds the
// input from its acceptance until its result is registered. A hit ends the walk early.
// No new transaction is accepted during a walk. A finished result waits in an output
// register while the block takes further transactions. A later search that finishes
// while that result is still waiting holds in its done state until the receiver takes
// the earlier result. Every element inside the configured size must be loaded before a
// search; the store has no reset.
module staircase_search_sorted_matrix #(
  parameter int MAX_ROWS   = ssm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = ssm_pkg::MAX_COLS_DEF,
  parameter int DATA_WIDTH = ssm_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssm_pkg::PADDR_W-1:0] paddr,
  input  logic [ssm_pkg::PDATA_W-1:0] pwdata,
  output logic [ssm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ssm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ssm_pkg::out_item_t          out_data
);

  logic [ssm_pkg::SIZE_W-1:0] num_rows;
  logic [ssm_pkg::SIZE_W-1:0] num_cols;
  ssm_pkg::ssm_cmd_t          cmd;
  ssm_pkg::ssm_status_t       status;

  ssm_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .num_rows (num_rows),
    .num_cols (num_cols)
  );

  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  ssm_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .num_rows (num_rows),
    .num_cols (num_cols),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[hdl/ssm_checker.sv]
`include "staircase_search_sorted_matrix_defines.svh"

module ssm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input ssm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ssm_pkg::out_item_t out_data
);

  // A stalled result holds its value.
  `SSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // A miss reports position zero.
  `SSM_ASSERT_NOW(a_miss_zero, out_valid && !out_data.found, out_data.hit_row == '0 && out_data.hit_col == '0, "miss with nonzero position")

  // An accepted search occupies the block in the next cycle.
  `SSM_ASSERT_NEXT(a_search_busy, in_valid && in_ready && in_data.func == ssm_pkg::FUNC_SEARCH, !in_ready, "ready after search start")

  // Loads never stall the input.
  `SSM_ASSERT_NEXT(a_load_stream, in_valid && in_ready && in_data.func == ssm_pkg::FUNC_LOAD, in_ready, "load stalled the input")

endmodule

bind staircase_search_sorted_matrix ssm_checker u_ssm_checker (.*);
